FILE: rtl/ihx_pkg.sv
// Shared types and constants for the IPv4 header extractor.
`default_nettype none
package ihx_pkg;

    localparam int IDX_W = 5;

    localparam logic [7:0]  MARK_FIRST   = 8'h08;
    localparam logic [7:0]  MARK_SECOND  = 8'h00;
    localparam logic [7:0]  MARK_THIRD   = 8'h45;
    localparam logic [IDX_W-1:0] HEADER_BYTES = 5'd20;
    localparam logic [7:0]  PROTO_TCP    = 8'd6;
    localparam logic [15:0] SUM_GOOD     = 16'hFFFF;

    localparam int OUT_BITS = 154;
    localparam int OUT_W    = 160;

    // One result item.
    typedef struct packed {
        logic [31:0] bad_sum_count;
        logic [15:0] dst_port;
        logic [15:0] src_port;
        logic        is_tcp;
        logic        header_sum_ok;
        logic [7:0]  protocol_number;
        logic [15:0] total_length;
        logic [31:0] dst_addr;
        logic [31:0] src_addr;
    } ihx_result_t;

    // Parser status seen by the top level.
    typedef struct packed {
        logic             capturing;
        logic [IDX_W-1:0] capture_index;
    } ihx_status_t;

endpackage
`default_nettype wire

FILE: rtl/ipv4_header_extractor.sv
// IPv4 header extractor: the last captured byte passes the input register and
// then the result register to reach m_tvalid; one byte is taken every cycle,
// stalling only while an unclaimed result waits there and the input register is full.
// One result per capture of CAPTURE_BYTES bytes, the 45 of the mark 08 00 45 being the first.
// Asynchronous active-low reset clears the search, the capture state, the
// bad checksum count and both stage valid flags.
`default_nettype none
module ipv4_header_extractor
    import ihx_pkg::*;
#(
    parameter int CAPTURE_BYTES = 24
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             s_tvalid,
    output logic                  s_tready,
    input  wire logic [7:0]       s_tdata,   // [7:0] data_byte
    output logic                  m_tvalid,
    input  wire logic             m_tready,
    // [31:0] src_addr, [63:32] dst_addr, [79:64] total_length,
    // [87:80] protocol_number, [88] header_sum_ok, [89] is_tcp,
    // [105:90] src_port, [121:106] dst_port, [153:122] bad_sum_count, rest zero
    output logic [OUT_W-1:0]      m_tdata
);

    logic        byte_valid;
    logic [7:0]  byte_data;
    logic        consume;
    logic        room;
    logic        res_valid;
    ihx_result_t result;
    ihx_status_t status;

    // Work on the held byte whenever the result register can take an item.
    assign consume = byte_valid && room;

    ihx_in_stage u_in (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .consume    (consume),
        .byte_valid (byte_valid),
        .byte_data  (byte_data)
    );

    ihx_parse #(
        .CAPTURE_BYTES (CAPTURE_BYTES)
    ) u_parse (
        .clk       (clk),
        .rst_n     (rst_n),
        .consume   (consume),
        .byte_data (byte_data),
        .res_valid (res_valid),
        .result    (result),
        .status    (status)
    );

    ihx_out_stage u_out (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (res_valid),
        .result   (result),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .room     (room)
    );

`ifndef SYNTHESIS
    a_index_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !status.capturing |-> status.capture_index == '0)
        else $error("capture index not zero outside a capture");

    a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
        status.capture_index < IDX_W'(CAPTURE_BYTES))
        else $error("capture index past capture length");

    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |-> !consume)
        else $error("byte consumed while result register blocked");

    a_result_on_capture: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> status.capturing && consume)
        else $error("result produced outside a capture");
`endif

endmodule
`default_nettype wire

FILE: rtl/ihx_in_stage.sv
// Input register for the raw capture byte stream.
`default_nettype none
module ihx_in_stage
    import ihx_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,    // [7:0] data_byte
    input  wire logic       consume,
    output logic            byte_valid,
    output logic [7:0]      byte_data
);

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] data_reg;

    // Take a new item when the register is empty or being drained.
    assign s_tready   = !valid_reg || consume;
    assign valid_next = (s_tvalid && s_tready) ? 1'b1 : (consume ? 1'b0 : valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Hold the payload until a new item arrives.
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            data_reg <= s_tdata;
        end
    end

    assign byte_valid = valid_reg;
    assign byte_data  = data_reg;

endmodule
`default_nettype wire

FILE: rtl/ihx_parse.sv
// Mark search, header capture and ones' complement checksum.
`default_nettype none
module ihx_parse
    import ihx_pkg::*;
#(
    parameter int CAPTURE_BYTES = 24
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       consume,
    input  wire logic [7:0] byte_data,
    output logic            res_valid,
    output ihx_result_t     result,
    output ihx_status_t     status
);

    typedef enum logic [1:0] {
        SEARCH,
        SAW_08,
        SAW_00,
        CAPTURE
    } phase_t;

    phase_t           phase_reg,  phase_next;
    logic [IDX_W-1:0] index_reg,  index_next;
    logic [7:0]       held_reg,   held_next;
    logic [15:0]      sum_reg,    sum_next;
    logic [31:0]      src_reg,    src_next;
    logic [31:0]      dst_reg,    dst_next;
    logic [15:0]      len_reg,    len_next;
    logic [7:0]       proto_reg,  proto_next;
    logic [31:0]      port_reg,   port_next;
    logic [31:0]      bad_reg,    bad_next;

    logic             take;
    logic [IDX_W-1:0] idx;
    logic [IDX_W-1:0] index_inc;
    logic [16:0]      sum_wide;
    logic             ok;
    logic             tcp;

    assign index_inc = index_reg + IDX_W'(1);
    assign sum_wide  = {1'b0, sum_reg} + {1'b0, held_reg, byte_data};

    always_comb
    begin
        phase_next = phase_reg;
        index_next = index_reg;
        held_next  = held_reg;
        sum_next   = sum_reg;
        src_next   = src_reg;
        dst_next   = dst_reg;
        len_next   = len_reg;
        proto_next = proto_reg;
        port_next  = port_reg;
        bad_next   = bad_reg;
        take       = 1'b0;
        idx        = index_reg;
        res_valid  = 1'b0;

        // Advance the mark search or the capture.
        if (consume)
        begin
            case (phase_reg)
                SEARCH:
                begin
                    if (byte_data == MARK_FIRST)
                    begin
                        phase_next = SAW_08;
                    end
                end
                SAW_08:
                begin
                    if (byte_data == MARK_SECOND)
                    begin
                        phase_next = SAW_00;
                    end
                    else if (byte_data == MARK_FIRST)
                    begin
                        phase_next = SAW_08;
                    end
                    else
                    begin
                        phase_next = SEARCH;
                    end
                end
                SAW_00:
                begin
                    if (byte_data == MARK_THIRD)
                    begin
                        phase_next = CAPTURE;
                        sum_next   = '0;
                        src_next   = '0;
                        dst_next   = '0;
                        len_next   = '0;
                        proto_next = '0;
                        port_next  = '0;
                        take       = 1'b1;
                        idx        = '0;
                        index_next = IDX_W'(1);
                    end
                    else if (byte_data == MARK_FIRST)
                    begin
                        phase_next = SAW_08;
                    end
                    else
                    begin
                        phase_next = SEARCH;
                    end
                end
                CAPTURE:
                begin
                    take = 1'b1;
                    if (index_inc == IDX_W'(CAPTURE_BYTES))
                    begin
                        phase_next = SEARCH;
                        index_next = '0;
                        res_valid  = 1'b1;
                    end
                    else
                    begin
                        index_next = index_inc;
                    end
                end
                default:
                begin
                    phase_next = SEARCH;
                end
            endcase
        end

        // Store the captured byte in its field; add each finished word.
        if (take)
        begin
            if (idx < HEADER_BYTES)
            begin
                if (!idx[0])
                begin
                    held_next = byte_data;
                end
                else
                begin
                    sum_next = sum_wide[15:0] + {15'd0, sum_wide[16]};
                end
            end
            if (idx == IDX_W'(2) || idx == IDX_W'(3))
            begin
                len_next = {len_next[7:0], byte_data};
            end
            else if (idx == IDX_W'(9))
            begin
                proto_next = byte_data;
            end
            else if (idx >= IDX_W'(12) && idx <= IDX_W'(15))
            begin
                src_next = {src_next[23:0], byte_data};
            end
            else if (idx >= IDX_W'(16) && idx <= IDX_W'(19))
            begin
                dst_next = {dst_next[23:0], byte_data};
            end
            else if (idx >= IDX_W'(20) && idx <= IDX_W'(23))
            begin
                port_next = {port_next[23:0], byte_data};
            end
        end

        ok  = (sum_next == SUM_GOOD);
        tcp = (proto_next == PROTO_TCP);

        // Count a failed checksum with the result that reports it.
        if (res_valid && !ok)
        begin
            bad_next = bad_reg + 32'd1;
        end

        result.src_addr        = src_next;
        result.dst_addr        = dst_next;
        result.total_length    = len_next;
        result.protocol_number = proto_next;
        result.header_sum_ok   = ok;
        result.is_tcp          = tcp;
        result.src_port        = tcp ? port_next[31:16] : 16'd0;
        result.dst_port        = tcp ? port_next[15:0]  : 16'd0;
        result.bad_sum_count   = bad_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= SEARCH;
            index_reg <= '0;
            held_reg  <= '0;
            sum_reg   <= '0;
            src_reg   <= '0;
            dst_reg   <= '0;
            len_reg   <= '0;
            proto_reg <= '0;
            port_reg  <= '0;
            bad_reg   <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            index_reg <= index_next;
            held_reg  <= held_next;
            sum_reg   <= sum_next;
            src_reg   <= src_next;
            dst_reg   <= dst_next;
            len_reg   <= len_next;
            proto_reg <= proto_next;
            port_reg  <= port_next;
            bad_reg   <= bad_next;
        end
    end

    assign status.capturing     = (phase_reg == CAPTURE);
    assign status.capture_index = index_reg;

endmodule
`default_nettype wire

FILE: rtl/ihx_out_stage.sv
// Result register driving the master-side stream.
`default_nettype none
module ihx_out_stage
    import ihx_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         load,
    input  wire ihx_result_t  result,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [OUT_W-1:0]  m_tdata,
    output logic              room
);

    logic        valid_reg;
    logic        valid_next;
    ihx_result_t data_reg;

    // Free when empty or when the waiting item leaves this cycle.
    assign room       = !valid_reg || m_tready;
    assign valid_next = load ? 1'b1 : (m_tready ? 1'b0 : valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Hold the result until taken.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= result;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {(OUT_W - OUT_BITS)'(0), data_reg};

endmodule
`default_nettype wire
